// ===== rtl/tccw_pkg.sv =====
// Package for the text console cell writer.
// Screen geometry, character and opcode codes, and the controller/datapath
// command and status types. No dependencies.
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_AW = $clog2(COLUMNS);
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TC_W   = $clog2(TAB_STOP + 1);

  localparam int OPC_W  = 2;
  localparam int BYTE_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;

  localparam logic [OPC_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [BYTE_W-1:0] CH_BLANK   = 8'd0;
  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'd7;

  typedef enum logic [2:0] {
    K_CHAR,
    K_TAB,
    K_NEWLINE,
    K_RETURN,
    K_READ,
    K_CLEAR,
    K_NOP
  } tccw_kind_e;

  typedef struct packed {
    logic put_char;
    logic put_space;
    logic tab_load;
    logic newline;
    logic cret;
    logic read_issue;
    logic clear_start;
    logic scroll_start;
    logic sweep_step;
    logic result_load;
    logic read_sel;
  } tccw_cmd_t;

  typedef struct packed {
    tccw_kind_e kind;
    logic       out_free;
    logic       adv_scroll;
    logic       nl_scroll;
    logic       tab_last;
    logic       sweep_last;
  } tccw_status_t;

endpackage

// ===== rtl/tccw_ctrl.sv =====
// Controller state machine for the text console cell writer.
// Sequences reset sweep, reads, tabs, scrolls and clears; uses tccw_pkg.
module tccw_ctrl import tccw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  tccw_status_t status_i,
  output tccw_cmd_t    cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_TAB    = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ret_tab_q, ret_tab_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      ret_tab_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_tab_q <= ret_tab_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    ret_tab_d  = ret_tab_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          unique case (status_i.kind)
            K_CHAR: begin
              cmd_o.put_char = 1'b1;
              if (status_i.adv_scroll) begin
                cmd_o.scroll_start = 1'b1;
                ret_tab_d          = 1'b0;
                state_d            = ST_SCROLL;
              end else begin
                cmd_o.result_load = 1'b1;
              end
            end
            K_NEWLINE: begin
              cmd_o.newline = 1'b1;
              if (status_i.nl_scroll) begin
                cmd_o.scroll_start = 1'b1;
                ret_tab_d          = 1'b0;
                state_d            = ST_SCROLL;
              end else begin
                cmd_o.result_load = 1'b1;
              end
            end
            K_RETURN: begin
              cmd_o.cret        = 1'b1;
              cmd_o.result_load = 1'b1;
            end
            K_TAB: begin
              cmd_o.tab_load = 1'b1;
              state_d        = ST_TAB;
            end
            K_READ: begin
              cmd_o.read_issue = 1'b1;
              state_d          = ST_READ;
            end
            K_CLEAR: begin
              cmd_o.clear_start = 1'b1;
              state_d           = ST_CLEAR;
            end
            default: begin
              cmd_o.result_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.result_load = 1'b1;
        cmd_o.read_sel    = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_TAB: begin
        cmd_o.put_space = 1'b1;
        if (status_i.adv_scroll) begin
          cmd_o.scroll_start = 1'b1;
          ret_tab_d          = !status_i.tab_last;
          state_d            = ST_SCROLL;
        end else if (status_i.tab_last) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          if (ret_tab_q) begin
            state_d = ST_TAB;
          end else begin
            cmd_o.result_load = 1'b1;
            state_d           = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/tccw_datapath.sv =====
// Datapath for the text console cell writer: cursor, row base, sweep and
// tab counters, character and attribute memories, result register.
// Uses tccw_pkg; driven by tccw_ctrl.
module tccw_datapath import tccw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tccw_cmd_t           cmd_i,
  output tccw_status_t        status_o,
  input  logic [OPC_W-1:0]    opcode_i,
  input  logic [BYTE_W-1:0]   char_code_i,
  input  logic [BYTE_W-1:0]   char_color_i,
  input  logic                write_color_i,
  input  logic [POS_W-1:0]    cell_index_i,
  input  logic                cfg_valid_i,
  input  logic [BYTE_W-1:0]   cfg_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [COL_W-1:0]    cursor_column_o,
  output logic [ROW_W-1:0]    cursor_row_o,
  output logic [POS_W-1:0]    cursor_position_o,
  output logic [BYTE_W-1:0]   read_char_o,
  output logic [BYTE_W-1:0]   read_attr_o
);

  logic [BYTE_W-1:0] char_mem [CELLS];
  logic [BYTE_W-1:0] attr_mem [CELLS];

  logic [COL_AW-1:0] col_q, col_d;
  logic [ROW_AW-1:0] row_q, row_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0] sweep_end_q, sweep_end_d;
  logic [BYTE_W-1:0] sweep_attr_q, sweep_attr_d;
  logic [TC_W-1:0]   tab_left_q, tab_left_d;
  logic [BYTE_W-1:0] blank_q;
  logic              out_valid_q;

  logic [BYTE_W-1:0] rd_char_q, rd_attr_q;
  logic              rd_ok_q;

  logic [ADDR_W-1:0] cur_phys, rd_phys, waddr;
  logic [BYTE_W-1:0] wchar, wattr;
  logic              char_we, attr_we;
  logic              at_last_col, at_last_row, rd_in_range;

  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (ADDR_W+1)'(CELLS)) sum = sum - (ADDR_W+1)'(CELLS);
    return sum[ADDR_W-1:0];
  endfunction

  assign at_last_col = (col_q == COL_AW'(COLUMNS - 1));
  assign at_last_row = (row_q == ROW_AW'(ROWS - 1));
  assign rd_in_range = (int'(cell_index_i) < CELLS);
  assign cur_phys    = phys_addr(pos_q, base_q);
  assign rd_phys     = phys_addr(ADDR_W'(cell_index_i), base_q);

  always_comb begin
    unique case (opcode_i)
      OP_PUT: begin
        unique case (char_code_i)
          CH_NEWLINE: status_o.kind = K_NEWLINE;
          CH_RETURN:  status_o.kind = K_RETURN;
          CH_TAB:     status_o.kind = K_TAB;
          default:    status_o.kind = K_CHAR;
        endcase
      end
      OP_READ:  status_o.kind = K_READ;
      OP_CLEAR: status_o.kind = K_CLEAR;
      default:  status_o.kind = K_NOP;
    endcase
    status_o.out_free   = !out_valid_q || !out_stall_i;
    status_o.adv_scroll = at_last_col && at_last_row;
    status_o.nl_scroll  = at_last_row;
    status_o.tab_last   = (tab_left_q == TC_W'(1));
    status_o.sweep_last = (sweep_addr_q == sweep_end_q);
  end

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    pos_d        = pos_q;
    phase_d      = phase_q;
    base_d       = base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    sweep_attr_d = sweep_attr_q;
    tab_left_d   = tab_left_q;

    if (cmd_i.clear_start) begin
      col_d        = '0;
      row_d        = '0;
      pos_d        = '0;
      phase_d      = '0;
      sweep_addr_d = '0;
      sweep_end_d  = ADDR_W'(CELLS - 1);
      sweep_attr_d = blank_q;
    end else if (cmd_i.put_char || cmd_i.put_space) begin
      if (at_last_col) begin
        col_d   = '0;
        phase_d = '0;
        if (at_last_row) begin
          pos_d = ADDR_W'(CELLS - COLUMNS);
        end else begin
          row_d = row_q + ROW_AW'(1);
          pos_d = pos_q + ADDR_W'(1);
        end
      end else begin
        col_d   = col_q + COL_AW'(1);
        pos_d   = pos_q + ADDR_W'(1);
        phase_d = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);
      end
    end else if (cmd_i.newline) begin
      col_d   = '0;
      phase_d = '0;
      if (at_last_row) begin
        pos_d = ADDR_W'(CELLS - COLUMNS);
      end else begin
        row_d = row_q + ROW_AW'(1);
        pos_d = pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
      end
    end else if (cmd_i.cret) begin
      col_d   = '0;
      phase_d = '0;
      pos_d   = pos_q - ADDR_W'(col_q);
    end

    if (cmd_i.tab_load) tab_left_d = TC_W'(TAB_STOP) - TC_W'(phase_q);
    else if (cmd_i.put_space) tab_left_d = tab_left_q - TC_W'(1);

    if (cmd_i.scroll_start) begin
      base_d       = (base_q == ADDR_W'(CELLS - COLUMNS)) ? '0 : base_q + ADDR_W'(COLUMNS);
      sweep_addr_d = base_q;
      sweep_end_d  = base_q + ADDR_W'(COLUMNS - 1);
      sweep_attr_d = blank_q;
    end else if (cmd_i.sweep_step) begin
      sweep_addr_d = sweep_addr_q + ADDR_W'(1);
    end
  end

  always_comb begin
    waddr   = cur_phys;
    wchar   = char_code_i;
    wattr   = char_color_i;
    char_we = 1'b0;
    attr_we = 1'b0;
    if (cmd_i.sweep_step) begin
      waddr   = sweep_addr_q;
      wchar   = CH_BLANK;
      wattr   = sweep_attr_q;
      char_we = 1'b1;
      attr_we = 1'b1;
    end else if (cmd_i.put_char) begin
      char_we = 1'b1;
      attr_we = write_color_i;
    end else if (cmd_i.put_space) begin
      wchar   = CH_SPACE;
      char_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_we) char_mem[waddr] <= wchar;
    if (attr_we) attr_mem[waddr] <= wattr;
    if (cmd_i.read_issue) begin
      rd_char_q <= char_mem[rd_phys];
      rd_attr_q <= attr_mem[rd_phys];
      rd_ok_q   <= rd_in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      pos_q        <= '0;
      phase_q      <= '0;
      base_q       <= '0;
      sweep_addr_q <= '0;
      sweep_end_q  <= ADDR_W'(CELLS - 1);
      sweep_attr_q <= RESET_ATTR;
      tab_left_q   <= '0;
      blank_q      <= RESET_ATTR;
      out_valid_q  <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      base_q       <= base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      sweep_attr_q <= sweep_attr_d;
      tab_left_q   <= tab_left_d;
      if (cfg_valid_i) blank_q <= cfg_data_i;
      if (cmd_i.result_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      cursor_column_o   <= COL_W'(col_d);
      cursor_row_o      <= ROW_W'(row_d);
      cursor_position_o <= POS_W'(pos_d);
      read_char_o       <= (cmd_i.read_sel && rd_ok_q) ? rd_char_q : '0;
      read_attr_o       <= (cmd_i.read_sel && rd_ok_q) ? rd_attr_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/text_console_cell_writer.sv =====
// Top level of the text console cell writer.
// Joins tccw_ctrl and tccw_datapath; uses tccw_pkg.
//
// channel   direction  handshake               payload
// -------   ---------  ----------------------  ------------------------------------------
// input     in         in_valid_i/in_stall_o   opcode, char_code, char_color, write_color,
//                                              cell_index
// result    out        out_valid_o/out_stall_i cursor_column, cursor_row, cursor_position,
//                                              read_char, read_attr
// config    in         cfg_valid_i/cfg_ready_o blank_color (cfg_data_i)
//
// Every item gives one result; an unused opcode changes nothing. A tab writes spaces up to
// the next tab stop; a scroll blanks COLUMNS cells, one blanked cell per cycle.
// Scrolling moves a row base pointer, so only the new bottom row is written.
// After reset a clearing pass over all CELLS cells (2000) runs with in_stall_o high.
// An item is taken only once the result register is empty or being taken.
module text_console_cell_writer import tccw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OPC_W-1:0]  opcode_i,
  input  logic [BYTE_W-1:0] char_code_i,
  input  logic [BYTE_W-1:0] char_color_i,
  input  logic              write_color_i,
  input  logic [POS_W-1:0]  cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  cursor_column_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [POS_W-1:0]  cursor_position_o,
  output logic [BYTE_W-1:0] read_char_o,
  output logic [BYTE_W-1:0] read_attr_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BYTE_W-1:0] cfg_data_i
);

  tccw_cmd_t    cmd;
  tccw_status_t status;
  logic         in_ready;

  assign in_stall_o  = !in_ready;
  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .opcode_i          (opcode_i),
    .char_code_i       (char_code_i),
    .char_color_i      (char_color_i),
    .write_color_i     (write_color_i),
    .cell_index_i      (cell_index_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .cursor_column_o   (cursor_column_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_position_o (cursor_position_o),
    .read_char_o       (read_char_o),
    .read_attr_o       (read_attr_o)
  );

endmodule
